@@ design/gmmcc_pkg.sv @@
package gmmcc_pkg;

  // Components per mixture.
  localparam int NUM_COMPONENTS = 5;
  localparam int NUM_MODELS     = 2;
  localparam int WORDS_PER_COMP = 10;
  localparam int NUM_TERMS      = 6;

  // Field widths.
  localparam int KIND_W  = 1;
  localparam int COMP_W  = 4;
  localparam int PIDX_W  = 4;
  localparam int PARAM_W = 32;
  localparam int PIX_W   = 8;
  localparam int OUT_W   = 48;

  // Internal widths.
  localparam int DIFF_W = 17;  // pixel minus mean, clamped to +/-65535
  localparam int PROD_W = 33;  // product of two differences
  localparam int TERM_W = 52;  // coefficient times product, clamped to +/-2^50
  localparam int Q_W    = 55;  // quadratic form
  localparam int COST_W = 56;  // bias plus half the quadratic form

  // Min-search tree over the components of one mixture.
  localparam int TREE_LVLS = $clog2(NUM_COMPONENTS);
  localparam int TREE_N    = 1 << TREE_LVLS;

  localparam longint DIFF_LIMIT  = 64'sd65535;
  localparam longint TERM_LIMIT  = 64'sd1 <<< 50;
  localparam longint COST_MAX    = (64'sd1 <<< 47) - 64'sd1;
  localparam longint COST_MIN    = -(64'sd1 <<< 47);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_t;

  typedef enum logic [PIDX_W-1:0] {
    PI_MEAN_R = 4'd0,
    PI_MEAN_G = 4'd1,
    PI_MEAN_B = 4'd2,
    PI_CXX    = 4'd3,
    PI_CXY    = 4'd4,
    PI_CXZ    = 4'd5,
    PI_CYY    = 4'd6,
    PI_CYZ    = 4'd7,
    PI_CZZ    = 4'd8,
    PI_BIAS   = 4'd9
  } param_idx_t;

  // Difference channels that form each quadratic term, and whether the term
  // lies on the diagonal (off-diagonal terms count twice).
  localparam int TERM_A [NUM_TERMS] = '{0, 0, 0, 1, 1, 2};
  localparam int TERM_B [NUM_TERMS] = '{0, 1, 2, 1, 2, 2};
  localparam bit TERM_DIAG [NUM_TERMS] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef logic signed [PARAM_W-1:0] word_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [COST_W-1:0]  cost_t;
  typedef logic [COMP_W-1:0]         comp_t;

endpackage

@@ design/gmmcc_req_if.sv @@
interface gmmcc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [gmmcc_pkg::KIND_W-1:0]         kind;
  logic                                 model_select;
  logic [gmmcc_pkg::COMP_W-1:0]         component;
  logic [gmmcc_pkg::PIDX_W-1:0]         param_index;
  logic signed [gmmcc_pkg::PARAM_W-1:0] param_value;
  logic [gmmcc_pkg::PIX_W-1:0]          red;
  logic [gmmcc_pkg::PIX_W-1:0]          green;
  logic [gmmcc_pkg::PIX_W-1:0]          blue;

  modport source (output valid, kind, model_select, component, param_index, param_value,
                  red, green, blue, input ready);
  modport sink (input valid, kind, model_select, component, param_index, param_value,
                red, green, blue, output ready);
endinterface

@@ design/gmmcc_rsp_if.sv @@
interface gmmcc_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [gmmcc_pkg::COMP_W-1:0]       bg_component;
  logic [gmmcc_pkg::COMP_W-1:0]       fg_component;
  logic signed [gmmcc_pkg::OUT_W-1:0] bg_cost;
  logic signed [gmmcc_pkg::OUT_W-1:0] fg_cost;

  modport source (output valid, bg_component, fg_component, bg_cost, fg_cost,
                  input ready);
  modport sink (input valid, bg_component, fg_component, bg_cost, fg_cost,
                output ready);
endinterface

@@ design/gmm_component_classifier.sv @@
// Gaussian-mixture component classifier. Each transaction on req is either a
// parameter load (kind = load), which writes one 32-bit word of one component
// of the background or foreground mixture into an on-chip table and returns
// nothing, or a pixel (kind = pixel), which returns one transaction on rsp with
// the cheapest component of each mixture and its Q16.16 cost, saturated to
// 48 bits. The cost of a component is its bias plus half the quadratic form of
// the pixel-minus-mean vector with the inverse covariance; ties go to the lower
// component index. The block takes one transaction per cycle while no result
// waits on rsp. A pixel passes through 3 + 1 + ceil(log2(NUM_COMPONENTS)) + 1
// register stages (8 with 5 components): difference, products, scaled terms,
// cost sum, the levels of the min-search tree, then saturation into the output
// register. The first stage loads at the accepting edge. The whole pipeline
// advances together and holds while a result waits on rsp, so req.ready is low
// exactly then. A load takes effect on the next cycle and every later pixel
// sees it; pixels already in flight carry their own copy of the parameters.
// Table words never loaded since reset are undefined, and every component that
// a pixel visits must be fully loaded.
module gmm_component_classifier (
  input logic         clk,
  input logic         rst,
  gmmcc_req_if.sink   req,
  gmmcc_rsp_if.source rsp
);

  localparam int N    = gmmcc_pkg::NUM_COMPONENTS;
  localparam int M    = gmmcc_pkg::NUM_MODELS;
  localparam int W    = gmmcc_pkg::WORDS_PER_COMP;
  localparam int T    = gmmcc_pkg::NUM_TERMS;
  localparam int L    = gmmcc_pkg::TREE_LVLS;
  localparam int TN   = gmmcc_pkg::TREE_N;
  localparam int NSTG = L + 5;

  // Parameter table, one flip-flop word per entry; every lane reads its own
  // fixed words.
  gmmcc_pkg::word_t tbl [M][N][W];

  // Pipeline registers.
  logic              vld [1:NSTG];
  gmmcc_pkg::diff_t  st1_d    [M][N][3];
  gmmcc_pkg::word_t  st1_coef [M][N][T];
  gmmcc_pkg::word_t  st1_bias [M][N];
  gmmcc_pkg::prod_t  st2_prod [M][N][T];
  gmmcc_pkg::word_t  st2_coef [M][N][T];
  gmmcc_pkg::word_t  st2_bias [M][N];
  gmmcc_pkg::term_t  st3_term [M][N][T];
  gmmcc_pkg::word_t  st3_bias [M][N];
  gmmcc_pkg::cost_t  tc  [L+1][M][TN];
  gmmcc_pkg::comp_t  ti  [L+1][M][TN];
  logic              tok [L+1][M][TN];
  gmmcc_pkg::cost_t  out_cost [M];
  gmmcc_pkg::comp_t  out_idx  [M];

  // Next values.
  gmmcc_pkg::diff_t  st1_d_next    [M][N][3];
  gmmcc_pkg::prod_t  st2_prod_next [M][N][T];
  gmmcc_pkg::term_t  st3_term_next [M][N][T];
  gmmcc_pkg::cost_t  cost_next     [M][N];
  gmmcc_pkg::cost_t  tc_next  [L+1][M][TN];
  gmmcc_pkg::comp_t  ti_next  [L+1][M][TN];
  logic              tok_next [L+1][M][TN];
  gmmcc_pkg::cost_t  sat_next [M];

  logic en;
  logic acc;
  logic pix_acc;
  logic [gmmcc_pkg::PIX_W-1:0] pix [3];

  // All stages move together; a waiting result freezes the whole pipeline.
  assign en      = !vld[NSTG] || rsp.ready;
  assign req.ready = en;
  assign acc     = req.valid && en;
  assign pix_acc = acc && (req.kind == gmmcc_pkg::KIND_PIXEL);

  assign pix[0] = req.red;
  assign pix[1] = req.green;
  assign pix[2] = req.blue;

  // Table writes: loads with an out-of-range component or index are dropped.
  always_ff @(posedge clk) begin
    for (int m = 0; m < M; m++) begin
      for (int n = 0; n < N; n++) begin
        for (int w = 0; w < W; w++) begin
          if (acc && (req.kind == gmmcc_pkg::KIND_LOAD) && (req.model_select == 1'(m)) &&
              (req.component == gmmcc_pkg::COMP_W'(n)) &&
              (req.param_index == gmmcc_pkg::PIDX_W'(w))) begin
            tbl[m][n][w] <= req.param_value;
          end
        end
      end
    end
  end

  // Stage 1: pixel minus mean, clamped.
  always_comb begin
    logic signed [gmmcc_pkg::PARAM_W+1:0] df;
    for (int m = 0; m < M; m++) begin
      for (int n = 0; n < N; n++) begin
        for (int c = 0; c < 3; c++) begin
          df = (gmmcc_pkg::PARAM_W+2)'($signed({1'b0, pix[c]}))
             - (gmmcc_pkg::PARAM_W+2)'(tbl[m][n][c]);
          if (df > (gmmcc_pkg::PARAM_W+2)'(gmmcc_pkg::DIFF_LIMIT)) begin
            st1_d_next[m][n][c] = gmmcc_pkg::DIFF_W'(gmmcc_pkg::DIFF_LIMIT);
          end else if (df < -(gmmcc_pkg::PARAM_W+2)'(gmmcc_pkg::DIFF_LIMIT)) begin
            st1_d_next[m][n][c] = -gmmcc_pkg::DIFF_W'(gmmcc_pkg::DIFF_LIMIT);
          end else begin
            st1_d_next[m][n][c] = df[gmmcc_pkg::DIFF_W-1:0];
          end
        end
      end
    end
  end

  // Stage 2: products of difference pairs.
  always_comb begin
    logic signed [2*gmmcc_pkg::DIFF_W-1:0] p;
    for (int m = 0; m < M; m++) begin
      for (int n = 0; n < N; n++) begin
        for (int k = 0; k < T; k++) begin
          p = (2*gmmcc_pkg::DIFF_W)'(st1_d[m][n][gmmcc_pkg::TERM_A[k]])
            * (2*gmmcc_pkg::DIFF_W)'(st1_d[m][n][gmmcc_pkg::TERM_B[k]]);
          st2_prod_next[m][n][k] = p[gmmcc_pkg::PROD_W-1:0];
        end
      end
    end
  end

  // Stage 3: coefficient times product, clamped to +/-2^50.
  always_comb begin
    logic signed [gmmcc_pkg::PARAM_W+gmmcc_pkg::PROD_W-1:0] t;
    for (int m = 0; m < M; m++) begin
      for (int n = 0; n < N; n++) begin
        for (int k = 0; k < T; k++) begin
          t = (gmmcc_pkg::PARAM_W+gmmcc_pkg::PROD_W)'(st2_coef[m][n][k])
            * (gmmcc_pkg::PARAM_W+gmmcc_pkg::PROD_W)'(st2_prod[m][n][k]);
          if (t > (gmmcc_pkg::PARAM_W+gmmcc_pkg::PROD_W)'(gmmcc_pkg::TERM_LIMIT)) begin
            st3_term_next[m][n][k] = gmmcc_pkg::TERM_W'(gmmcc_pkg::TERM_LIMIT);
          end else if (t < -(gmmcc_pkg::PARAM_W+gmmcc_pkg::PROD_W)'(gmmcc_pkg::TERM_LIMIT))
          begin
            st3_term_next[m][n][k] = -gmmcc_pkg::TERM_W'(gmmcc_pkg::TERM_LIMIT);
          end else begin
            st3_term_next[m][n][k] = t[gmmcc_pkg::TERM_W-1:0];
          end
        end
      end
    end
  end

  // Stage 4: quadratic form with off-diagonal terms doubled, halved with
  // rounding toward minus infinity, plus the bias.
  always_comb begin
    logic signed [gmmcc_pkg::Q_W-1:0] q;
    for (int m = 0; m < M; m++) begin
      for (int n = 0; n < N; n++) begin
        q = '0;
        for (int k = 0; k < T; k++) begin
          if (gmmcc_pkg::TERM_DIAG[k]) begin
            q = q + gmmcc_pkg::Q_W'(st3_term[m][n][k]);
          end else begin
            q = q + (gmmcc_pkg::Q_W'(st3_term[m][n][k]) <<< 1);
          end
        end
        cost_next[m][n] = gmmcc_pkg::COST_W'(st3_bias[m][n])
                        + gmmcc_pkg::COST_W'(q >>> 1);
      end
    end
  end

  // Min-search tree. Level 0 takes the lane costs, and padding leaves are
  // marked empty. In every later level the left leaf holds the lower index,
  // so it wins ties.
  always_comb begin
    for (int m = 0; m < M; m++) begin
      for (int i = 0; i < TN; i++) begin
        if (i < N) begin
          tc_next[0][m][i]  = cost_next[m][i];
          ti_next[0][m][i]  = gmmcc_pkg::COMP_W'(i);
          tok_next[0][m][i] = 1'b1;
        end else begin
          tc_next[0][m][i]  = '0;
          ti_next[0][m][i]  = '0;
          tok_next[0][m][i] = 1'b0;
        end
      end
    end
    for (int l = 1; l <= L; l++) begin
      for (int m = 0; m < M; m++) begin
        for (int i = 0; i < TN; i++) begin
          tc_next[l][m][i]  = tc[l][m][i];
          ti_next[l][m][i]  = ti[l][m][i];
          tok_next[l][m][i] = tok[l][m][i];
          if (i < (TN >> l)) begin
            if (!tok[l-1][m][2*i+1] ||
                (tok[l-1][m][2*i] && (tc[l-1][m][2*i] <= tc[l-1][m][2*i+1]))) begin
              tc_next[l][m][i]  = tc[l-1][m][2*i];
              ti_next[l][m][i]  = ti[l-1][m][2*i];
              tok_next[l][m][i] = tok[l-1][m][2*i];
            end else begin
              tc_next[l][m][i]  = tc[l-1][m][2*i+1];
              ti_next[l][m][i]  = ti[l-1][m][2*i+1];
              tok_next[l][m][i] = 1'b1;
            end
          end
        end
      end
    end
  end

  // Saturation into the 48-bit output range.
  always_comb begin
    for (int m = 0; m < M; m++) begin
      if (tc[L][m][0] > gmmcc_pkg::COST_W'(gmmcc_pkg::COST_MAX)) begin
        sat_next[m] = gmmcc_pkg::COST_W'(gmmcc_pkg::COST_MAX);
      end else if (tc[L][m][0] < gmmcc_pkg::COST_W'(gmmcc_pkg::COST_MIN)) begin
        sat_next[m] = gmmcc_pkg::COST_W'(gmmcc_pkg::COST_MIN);
      end else begin
        sat_next[m] = tc[L][m][0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < M; m++) begin
        for (int n = 0; n < N; n++) begin
          st1_d[m][n]   <= st1_d_next[m][n];
          st1_bias[m][n] <= tbl[m][n][gmmcc_pkg::PI_BIAS];
          st2_bias[m][n] <= st1_bias[m][n];
          st3_bias[m][n] <= st2_bias[m][n];
          for (int k = 0; k < T; k++) begin
            st1_coef[m][n][k] <= tbl[m][n][int'(gmmcc_pkg::PI_CXX) + k];
            st2_coef[m][n][k] <= st1_coef[m][n][k];
            st2_prod[m][n][k] <= st2_prod_next[m][n][k];
            st3_term[m][n][k] <= st3_term_next[m][n][k];
          end
        end
        out_cost[m] <= sat_next[m];
        out_idx[m]  <= ti[L][m][0];
      end
      tc  <= tc_next;
      ti  <= ti_next;
      tok <= tok_next;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= NSTG; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= pix_acc;
      for (int s = 2; s <= NSTG; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  assign rsp.valid        = vld[NSTG];
  assign rsp.bg_component = out_idx[0];
  assign rsp.fg_component = out_idx[1];
  assign rsp.bg_cost      = out_cost[0][gmmcc_pkg::OUT_W-1:0];
  assign rsp.fg_cost      = out_cost[1][gmmcc_pkg::OUT_W-1:0];

endmodule

@@ design/gmmcc_checker.sv @@
module gmmcc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [gmmcc_pkg::COMP_W-1:0]       bg_component,
  input logic [gmmcc_pkg::COMP_W-1:0]       fg_component,
  input logic signed [gmmcc_pkg::OUT_W-1:0] bg_cost,
  input logic signed [gmmcc_pkg::OUT_W-1:0] fg_cost
);

  // A result that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(bg_component) && $stable(fg_component) &&
      $stable(bg_cost) && $stable(fg_cost))
    else $error("result payload changed while stalled");

  // The input side is blocked exactly while a result waits.
  a_ready_tracks_stall: assert property (@(posedge clk) disable iff (rst)
    req_ready == (!rsp_valid || rsp_ready))
    else $error("input ready does not follow output stall");

  // No result leaves the block right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result offered after reset");

  // Winning indices name real components.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (bg_component < gmmcc_pkg::COMP_W'(gmmcc_pkg::NUM_COMPONENTS)) &&
      (fg_component < gmmcc_pkg::COMP_W'(gmmcc_pkg::NUM_COMPONENTS)))
    else $error("component index out of range");

endmodule

bind gmm_component_classifier gmmcc_checker u_gmmcc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .bg_component (rsp.bg_component),
  .fg_component (rsp.fg_component),
  .bg_cost      (rsp.bg_cost),
  .fg_cost      (rsp.fg_cost)
);
